// ===== rtl/i2cmbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cmbs_pkg;

  // Transaction phase
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_SLA_W     = 4'd2,
    PH_ADDR_HI   = 4'd3,
    PH_ADDR_LO   = 4'd4,
    PH_DATA      = 4'd5,
    PH_REP_START = 4'd6,
    PH_SLA_R     = 4'd7,
    PH_RX        = 4'd8
  } phase_e;

  // Byte engine command
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_SEND      = 3'd2,
    CMD_RECV_NACK = 3'd3,
    CMD_STOP      = 3'd4
  } cmd_e;

  // Input item kind
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DEV_ADDR     = 1'b0;
  localparam logic CFG_MAX_ATTEMPTS = 1'b1;

  // Bus status codes, upper five bits (low three bits are don't-care)
  localparam logic [4:0] ST_START      = 5'h01;  // 0x08
  localparam logic [4:0] ST_REP_START  = 5'h02;  // 0x10
  localparam logic [4:0] ST_SLA_W_ACK  = 5'h03;  // 0x18
  localparam logic [4:0] ST_SLA_W_NACK = 5'h04;  // 0x20
  localparam logic [4:0] ST_DATA_ACK   = 5'h05;  // 0x28
  localparam logic [4:0] ST_ARB_LOST   = 5'h07;  // 0x38
  localparam logic [4:0] ST_SLA_R_ACK  = 5'h08;  // 0x40
  localparam logic [4:0] ST_RX_ACK     = 5'h0A;  // 0x50
  localparam logic [4:0] ST_RX_NACK    = 5'h0B;  // 0x58

  localparam logic [6:0] DEV_ADDR_RST     = 7'd80;
  localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd3;

  // One result of the sequencer
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx;
    logic       done;
    logic       failed;
    logic [7:0] data;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/i2cmbs_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cmbs_fsm (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [1:0]           kind_i,
  input  wire logic [15:0]          mem_address_i,
  input  wire logic [7:0]           write_data_i,
  input  wire logic [7:0]           bus_status_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic [6:0]           dev_addr_i,
  input  wire logic [7:0]           max_attempts_i,
  output i2cmbs_pkg::result_t       res_o
);
  import i2cmbs_pkg::*;

  phase_e      phase_q, phase_d;
  logic        is_write_q, is_write_d;
  logic [7:0]  attempts_q, attempts_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      is_write_q <= 1'b0;
      attempts_q <= '0;
      addr_q     <= '0;
      data_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      is_write_q <= is_write_d;
      attempts_q <= attempts_d;
      addr_q     <= addr_d;
      data_q     <= data_d;
    end
  end

  logic [4:0] st;
  logic [7:0] sla;
  logic       st_is_start;

  assign st          = bus_status_i[7:3];
  assign sla         = {dev_addr_i, 1'b0};
  assign st_is_start = (st == ST_START) || (st == ST_REP_START);

  always_comb begin
    phase_d    = phase_q;
    is_write_d = is_write_q;
    attempts_d = attempts_q;
    addr_d     = addr_q;
    data_d     = data_q;
    res_o      = '{cmd: CMD_NONE, tx: 8'h00, done: 1'b0, failed: 1'b0, data: 8'h00};

    if ((kind_i == KIND_READ) || (kind_i == KIND_WRITE)) begin
      if (phase_q == PH_IDLE) begin
        is_write_d = (kind_i == KIND_WRITE);
        addr_d     = mem_address_i;
        data_d     = write_data_i;
        if (max_attempts_i == 8'd0) begin
          attempts_d   = 8'd0;
          res_o.done   = 1'b1;
          res_o.failed = 1'b1;
        end else begin
          attempts_d = 8'd1;
          res_o.cmd  = CMD_START;
          phase_d    = PH_START;
        end
      end
    end else if ((kind_i == KIND_STATUS) && (phase_q != PH_IDLE)) begin
      if ((st == ST_ARB_LOST) && (phase_q != PH_RX)) begin
        // lost arbitration: retake the bus, attempt not counted
        res_o.cmd = CMD_START;
        phase_d   = PH_START;
      end else begin
        unique case (phase_q)
          PH_START: begin
            if (st_is_start) begin
              res_o.cmd = CMD_SEND;
              res_o.tx  = sla;
              phase_d   = PH_SLA_W;
            end else begin
              // bus never taken, so no stop
              res_o.done   = 1'b1;
              res_o.failed = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          PH_SLA_W: begin
            if (st == ST_SLA_W_ACK) begin
              res_o.cmd = CMD_SEND;
              res_o.tx  = addr_q[15:8];
              phase_d   = PH_ADDR_HI;
            end else if ((st == ST_SLA_W_NACK) && (attempts_q < max_attempts_i)) begin
              attempts_d = attempts_q + 8'd1;
              res_o.cmd  = CMD_START;
              phase_d    = PH_START;
            end else begin
              res_o.cmd    = CMD_STOP;
              res_o.done   = 1'b1;
              res_o.failed = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          PH_ADDR_HI: begin
            if (st == ST_DATA_ACK) begin
              res_o.cmd = CMD_SEND;
              res_o.tx  = addr_q[7:0];
              phase_d   = PH_ADDR_LO;
            end else begin
              res_o.cmd    = CMD_STOP;
              res_o.done   = 1'b1;
              res_o.failed = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          PH_ADDR_LO: begin
            if (st != ST_DATA_ACK) begin
              res_o.cmd    = CMD_STOP;
              res_o.done   = 1'b1;
              res_o.failed = 1'b1;
              phase_d      = PH_IDLE;
            end else if (is_write_q) begin
              res_o.cmd = CMD_SEND;
              res_o.tx  = data_q;
              phase_d   = PH_DATA;
            end else begin
              res_o.cmd = CMD_START;
              phase_d   = PH_REP_START;
            end
          end
          PH_DATA: begin
            res_o.cmd    = CMD_STOP;
            res_o.done   = 1'b1;
            res_o.failed = (st != ST_DATA_ACK);
            phase_d      = PH_IDLE;
          end
          PH_REP_START: begin
            if (st_is_start) begin
              res_o.cmd = CMD_SEND;
              res_o.tx  = sla | 8'h01;
              phase_d   = PH_SLA_R;
            end else begin
              res_o.cmd    = CMD_STOP;
              res_o.done   = 1'b1;
              res_o.failed = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          PH_SLA_R: begin
            if (st == ST_SLA_R_ACK) begin
              res_o.cmd = CMD_RECV_NACK;
              phase_d   = PH_RX;
            end else begin
              res_o.cmd    = CMD_STOP;
              res_o.done   = 1'b1;
              res_o.failed = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          PH_RX: begin
            res_o.cmd  = CMD_STOP;
            res_o.done = 1'b1;
            phase_d    = PH_IDLE;
            if ((st == ST_RX_ACK) || (st == ST_RX_NACK)) begin
              res_o.data = rx_byte_i;
            end else begin
              res_o.failed = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_memory_byte_transaction_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    kind, mem_address, write_data,
//                                                 bus_status, rx_byte
// out       output     out_valid_o / out_ready_i  command, tx_byte, done_res,
//                                                 failed, read_data
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// Every accepted transfer yields exactly one result transfer, registered on
// the same edge, visible the next cycle; one transfer per cycle unless stalled.
// The output register holds the result under back-pressure; in_ready_o stays
// high as long as that register is empty or being drained in the same cycle.
// Reset returns the sequencer to idle with device address 80, three attempts.

module i2c_memory_byte_transaction_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // input transfer
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] mem_address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [7:0]  bus_status_i,
  input  wire logic [7:0]  rx_byte_i,
  // result transfer
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       command_o,
  output logic [7:0]       tx_byte_o,
  output logic             done_res_o,
  output logic             failed_o,
  output logic [7:0]       read_data_o
);
  import i2cmbs_pkg::*;

  // Configuration registers
  logic [6:0] dev_addr_q;
  logic [7:0] max_attempts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q     <= DEV_ADDR_RST;
      max_attempts_q <= MAX_ATTEMPTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEV_ADDR:     dev_addr_q     <= cfg_data_i[6:0];
        CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accept a new item whenever the result slot is free or draining now.
  logic    in_fire;
  result_t res;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  i2cmbs_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_fire),
    .kind_i         (kind_i),
    .mem_address_i  (mem_address_i),
    .write_data_i   (write_data_i),
    .bus_status_i   (bus_status_i),
    .rx_byte_i      (rx_byte_i),
    .dev_addr_i     (dev_addr_q),
    .max_attempts_i (max_attempts_q),
    .res_o          (res)
  );

  // Result register
  logic    out_valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign command_o   = res_q.cmd;
  assign tx_byte_o   = res_q.tx;
  assign done_res_o  = res_q.done;
  assign failed_o    = res_q.failed;
  assign read_data_o = res_q.data;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import i2cmbs_pkg::*;

  // Status codes the package leaves out (upper five bits only)
  localparam logic [4:0] ST_DATA_NACK  = 5'h06;  // 0x30
  localparam logic [4:0] ST_SLA_R_NACK = 5'h09;  // 0x48
  // Kind value with no meaning; the sequencer must ignore it
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 220;  // transfers per phase that the sequencer acts on
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off to back the block up
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  status;
    logic [7:0]  rx;
  } bus_item_t;

  // Directed row: one input transfer, plus an optional hand-typed result
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  status;
    logic [7:0]  rx;
    logic        typed;
    cmd_e        cmd;
    logic [7:0]  tx;
    logic        done;
    logic        failed;
    logic [7:0]  data;
  } directed_row_t;

  // Reset settings: device 80 (SLA+W 0xA0), three attempts.
  localparam int NUM_ROWS = 25;
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // stray status and unused kind while idle: both ignored
    '{KIND_STATUS, 'h0000, 'h00, 'h08, 'h00, 1, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_UNUSED, 'hFFFF, 'hFF, 'hFF, 'hFF, 1, CMD_NONE,  0, 0, 0, 'h00},
    // write at top address; a read request mid-transaction is dropped
    '{KIND_WRITE,  'hFFFF, 'hFF, 'h00, 'h00, 1, CMD_START, 0, 0, 0, 'h00},
    '{KIND_READ,   'h5555, 'h00, 'h00, 'h00, 1, CMD_NONE,  0, 0, 0, 'h00},
    // start with junk in the low status bits, then NACK until attempts run out
    '{KIND_STATUS, 'h0000, 'h00, 'h0F, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h20, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h10, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h20, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h08, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h27, 'h00, 1, CMD_STOP,  0, 1, 1, 'h00},
    // full read at address zero, with one arbitration loss on the way
    '{KIND_READ,   'h0000, 'h00, 'h00, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h38, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h08, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h18, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h28, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h28, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h10, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h40, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h58, 'hFF, 1, CMD_STOP,  0, 1, 0, 'hFF},
    // first start never acknowledged: fail with no stop
    '{KIND_WRITE,  'h8001, 'h00, 'h00, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h30, 'h00, 1, CMD_NONE,  0, 1, 1, 'h00},
    // write broken by an unexpected status after the address high byte
    '{KIND_WRITE,  'h1234, 'hA5, 'h00, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h08, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'h18, 'h00, 0, CMD_NONE,  0, 0, 0, 'h00},
    '{KIND_STATUS, 'h0000, 'h00, 'hFF, 'h00, 1, CMD_STOP,  0, 1, 1, 'h00}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [15:0] mem_address_i;
  logic [7:0]  write_data_i;
  logic [7:0]  bus_status_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  command_o;
  logic [7:0]  tx_byte_o;
  logic        done_res_o;
  logic        failed_o;
  logic [7:0]  read_data_o;

  i2c_memory_byte_transaction_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .mem_address_i(mem_address_i),
    .write_data_i (write_data_i),
    .bus_status_i (bus_status_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_o    (command_o),
    .tx_byte_o    (tx_byte_o),
    .done_res_o   (done_res_o),
    .failed_o     (failed_o),
    .read_data_o  (read_data_o)
  );

  // Expected engine commands, oldest first
  result_t pending_results[$];
  int      mismatch_count = 0;
  int      result_count   = 0;

  // Knobs shared by the two traffic processes
  bit stall_on = 1'b1;  // random gaps on both sides
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off

  // Shadow of the sequencer: registers and transaction state
  logic [6:0]  reg_dev_addr;
  logic [7:0]  reg_max_tries;
  phase_e      seq_phase;
  logic        seq_is_write;
  logic [7:0]  seq_tries;
  logic [15:0] seq_addr;
  logic [7:0]  seq_wdata;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result of a transaction that ends here; caller's phase goes idle
  function automatic result_t closing(input cmd_e c, input logic fail);
    result_t r;
    r        = '0;
    r.cmd    = c;
    r.done   = 1'b1;
    r.failed = fail;
    return r;
  endfunction

  // Next engine command for one accepted transfer; updates the shadow state.
  task automatic sequencer_step(input bus_item_t it, output result_t r);
    logic [4:0] st;
    logic [7:0] sla;
    r   = '0;
    st  = it.status[7:3];  // low three status bits carry no meaning
    sla = {reg_dev_addr, 1'b0};
    if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
      if (seq_phase == PH_IDLE) begin
        seq_is_write = (it.kind == KIND_WRITE);
        seq_addr     = it.addr;
        seq_wdata    = it.wdata;
        if (reg_max_tries == 8'd0) begin
          // no attempt allowed at all: fail on the spot, bus untouched
          seq_tries = 8'd0;
          r = closing(CMD_NONE, 1'b1);
        end else begin
          seq_tries = 8'd1;
          r.cmd     = CMD_START;
          seq_phase = PH_START;
        end
      end
    end else if (it.kind == KIND_STATUS && seq_phase != PH_IDLE) begin
      if (st == ST_ARB_LOST && seq_phase != PH_RX) begin
        // lost the bus: go again from start, attempt not counted
        r.cmd     = CMD_START;
        seq_phase = PH_START;
      end else begin
        case (seq_phase)
          PH_START: begin
            if (st == ST_START || st == ST_REP_START) begin
              r.cmd     = CMD_SEND;
              r.tx      = sla;
              seq_phase = PH_SLA_W;
            end else begin
              r = closing(CMD_NONE, 1'b1);  // never owned the bus, so no stop
            end
          end
          PH_SLA_W: begin
            if (st == ST_SLA_W_ACK) begin
              r.cmd     = CMD_SEND;
              r.tx      = seq_addr[15:8];
              seq_phase = PH_ADDR_HI;
            end else if (st == ST_SLA_W_NACK && seq_tries < reg_max_tries) begin
              seq_tries = seq_tries + 8'd1;
              r.cmd     = CMD_START;
              seq_phase = PH_START;
            end else begin
              r = closing(CMD_STOP, 1'b1);
            end
          end
          PH_ADDR_HI: begin
            if (st == ST_DATA_ACK) begin
              r.cmd     = CMD_SEND;
              r.tx      = seq_addr[7:0];
              seq_phase = PH_ADDR_LO;
            end else begin
              r = closing(CMD_STOP, 1'b1);
            end
          end
          PH_ADDR_LO: begin
            if (st != ST_DATA_ACK) begin
              r = closing(CMD_STOP, 1'b1);
            end else if (seq_is_write) begin
              r.cmd     = CMD_SEND;
              r.tx      = seq_wdata;
              seq_phase = PH_DATA;
            end else begin
              r.cmd     = CMD_START;
              seq_phase = PH_REP_START;
            end
          end
          PH_DATA: r = closing(CMD_STOP, st != ST_DATA_ACK);
          PH_REP_START: begin
            if (st == ST_START || st == ST_REP_START) begin
              r.cmd     = CMD_SEND;
              r.tx      = sla | 8'h01;
              seq_phase = PH_SLA_R;
            end else begin
              r = closing(CMD_STOP, 1'b1);
            end
          end
          PH_SLA_R: begin
            if (st == ST_SLA_R_ACK) begin
              r.cmd     = CMD_RECV_NACK;
              seq_phase = PH_RX;
            end else begin
              r = closing(CMD_STOP, 1'b1);
            end
          end
          PH_RX: begin
            if (st == ST_RX_ACK || st == ST_RX_NACK) begin
              r      = closing(CMD_STOP, 1'b0);
              r.data = it.rx;
            end else begin
              r = closing(CMD_STOP, 1'b1);
            end
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
    end
    if (r.done) seq_phase = PH_IDLE;
  endtask

  // Status the engine would most likely report next, with some faults mixed in
  function automatic logic [7:0] plausible_status();
    logic [4:0] code;
    int         roll;
    roll = $urandom_range(99);
    if (roll < 4) return {ST_ARB_LOST, 3'($urandom_range(7))};
    if (roll < 8) return 8'($urandom_range(255));
    case (seq_phase)
      PH_START, PH_REP_START:
        code = ($urandom_range(1) != 0) ? ST_START : ST_REP_START;
      PH_SLA_W:   code = (roll < 25) ? ST_SLA_W_NACK : ST_SLA_W_ACK;
      PH_ADDR_HI,
      PH_ADDR_LO: code = (roll < 12) ? ST_DATA_NACK : ST_DATA_ACK;
      PH_DATA:    code = (roll < 16) ? ST_DATA_NACK : ST_DATA_ACK;
      PH_SLA_R:   code = (roll < 16) ? ST_SLA_R_NACK : ST_SLA_R_ACK;
      PH_RX:      code = ($urandom_range(1) != 0) ? ST_RX_ACK : ST_RX_NACK;
      default:    code = 5'($urandom_range(31));
    endcase
    return {code, 3'($urandom_range(7))};
  endfunction

  // Mostly well-formed transactions; acts is clear for transfers that are ignored
  task automatic random_item(output bus_item_t it, output bit acts);
    int roll;
    roll      = $urandom_range(99);
    it.addr   = 16'($urandom);
    it.wdata  = 8'($urandom);
    it.status = 8'($urandom);
    it.rx     = 8'($urandom);
    acts      = 1'b0;
    if (roll < 4) begin
      it.kind = KIND_UNUSED;
    end else if (seq_phase == PH_IDLE) begin
      if (roll < 10) begin
        it.kind = KIND_STATUS;  // stray status while idle
      end else begin
        it.kind = ($urandom_range(1) != 0) ? KIND_WRITE : KIND_READ;
        acts    = 1'b1;
      end
    end else if (roll < 9) begin
      it.kind = ($urandom_range(1) != 0) ? KIND_WRITE : KIND_READ;  // request while busy
    end else begin
      it.kind   = KIND_STATUS;
      it.status = plausible_status();
      acts      = 1'b1;
    end
  endtask

  // Offer one transfer from a falling edge; returns at the falling edge after it.
  // Gaps come with a 12% chance per transfer and keep the sender idle about 20%.
  task automatic send_item(input bus_item_t it, input bit typed, input result_t typed_want);
    result_t want;
    if (stall_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    mem_address_i <= it.addr;
    write_data_i  <= it.wdata;
    bus_status_i  <= it.status;
    rx_byte_i     <= it.rx;
    do @(posedge clk_i); while (!in_ready_o);
    sequencer_step(it, want);
    pending_results.push_back(typed ? typed_want : want);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx == CFG_DEV_ADDR) reg_dev_addr = value[6:0];
    else                     reg_max_tries = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
             $time, result_count, what, got, want);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready_i <= !(stall_on && $urandom_range(99) < 20);
      end
    end
  end

  // Every result transfer is checked against the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, command", command_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (command_o !== want.cmd)      report_mismatch("command", command_o, want.cmd);
        if (tx_byte_o !== want.tx)       report_mismatch("tx_byte", tx_byte_o, want.tx);
        if (done_res_o !== want.done)    report_mismatch("done", done_res_o, want.done);
        if (failed_o !== want.failed)    report_mismatch("failed", failed_o, want.failed);
        if (read_data_o !== want.data)   report_mismatch("read_data", read_data_o, want.data);
      end
    end
  end

  initial begin : stimulus
    bus_item_t     it;
    directed_row_t row;
    result_t       typed_want;
    bit            acts;
    int            acted;
    logic [7:0]    dev_val;
    logic [7:0]    tries_val;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_DEV_ADDR;
    cfg_data_i    = 8'h00;
    in_valid_i    = 1'b0;
    kind_i        = KIND_READ;
    mem_address_i = 16'h0000;
    write_data_i  = 8'h00;
    bus_status_i  = 8'h00;
    rx_byte_i     = 8'h00;

    reg_dev_addr  = DEV_ADDR_RST;
    reg_max_tries = MAX_ATTEMPTS_RST;
    seq_phase     = PH_IDLE;
    seq_is_write  = 1'b0;
    seq_tries     = 8'd0;
    seq_addr      = 16'h0000;
    seq_wdata     = 8'h00;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows under reset settings
    for (int i = 0; i < NUM_ROWS; i++) begin
      row        = DIRECTED_ROWS[i];
      it         = '{row.kind, row.addr, row.wdata, row.status, row.rx};
      typed_want = '{row.cmd, row.tx, row.done, row.failed, row.data};
      send_item(it, row.typed, typed_want);
    end

    // Random phases, each under its own register settings.
    // Phase 0 is the top extreme, 1 and 2 the bottom (2 allows no attempt),
    // 3 runs with no gaps anywhere, 4 backs the block up with a long hold-off.
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      repeat (2) @(negedge clk_i);
      case (p)
        0:       begin dev_val = 8'hFF; tries_val = 8'd255; end
        1:       begin dev_val = 8'h00; tries_val = 8'd1;   end
        2:       begin dev_val = 8'h80; tries_val = 8'd0;   end
        default: begin dev_val = 8'($urandom); tries_val = 8'($urandom_range(6, 1)); end
      endcase
      write_reg(CFG_DEV_ADDR, dev_val);
      write_reg(CFG_MAX_ATTEMPTS, tries_val);
      stall_on = (p != 3);
      if (p == 4) hold_req = 1'b1;
      acted = 0;
      while (acted < PHASE_ITEMS) begin
        random_item(it, acts);
        send_item(it, 1'b0, '0);
        if (acts) acted++;
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("i2c_memory_byte_transaction_sequencer verification clean");
    end else begin
      $display("i2c_memory_byte_transaction_sequencer verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("i2c_memory_byte_transaction_sequencer verification failed");
    $finish;
  end

endmodule
